FILE: hw/rtl/crv_pkg.sv
package crv_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;
    localparam logic [31:0] FOUR_BITS = 32'h40800000;

    typedef enum logic [2:0] {
        FAIL_OK     = 3'd0,
        FAIL_VER    = 3'd1,
        FAIL_NONFIN = 3'd2,
        FAIL_RANGE  = 3'd3,
        FAIL_CRC    = 3'd4
    } t_fail;

    // finished record fields handed to the verdict stage
    typedef struct packed {
        logic [31:0] version;
        logic [31:0] low_bits;
        logic [31:0] high_bits;
        logic [31:0] crc_word;
        logic [31:0] calc;
    } t_record;

    // byte-wide reflected crc-32 update
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // monotonic ordering key for float bit patterns
    function automatic logic [31:0] order_key(input logic [31:0] f);
        return f[31] ? ~f : (f | 32'h80000000);
    endfunction

    function automatic logic is_zero(input logic [31:0] f);
        return f[30:0] == 31'd0;
    endfunction

    function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
        if (is_zero(a) && is_zero(b)) begin
            return 1'b0;
        end
        return order_key(a) < order_key(b);
    endfunction

endpackage

FILE: hw/rtl/crv_collect.sv
module crv_collect (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_rec_byte,
    input  logic                i_first,
    output logic                o_done,
    output crv_pkg::t_record    o_rec
);

    logic [3:0]  r_idx;
    logic [31:0] r_crc;
    logic [31:0] r_ver;
    logic [31:0] r_low;
    logic [31:0] r_high;
    logic [31:0] r_cw;
    logic [3:0]  idx;
    logic [31:0] base_crc;
    logic [31:0] base_ver;
    logic [31:0] base_low;
    logic [31:0] base_high;
    logic [31:0] base_cw;
    logic [31:0] n_crc;
    logic [31:0] n_ver;
    logic [31:0] n_low;
    logic [31:0] n_high;
    logic [31:0] n_cw;
    logic [31:0] shifted;

    // restart on first flag
    always_comb begin
        idx       = i_first ? 4'd0 : r_idx;
        base_crc  = i_first ? crv_pkg::CRC_ONES : r_crc;
        base_ver  = i_first ? 32'd0 : r_ver;
        base_low  = i_first ? 32'd0 : r_low;
        base_high = i_first ? 32'd0 : r_high;
        base_cw   = i_first ? 32'd0 : r_cw;
        shifted   = {24'd0, i_rec_byte} << {idx[1:0], 3'b000};
        n_crc     = (idx < 4'd12) ? crv_pkg::crc_byte(base_crc, i_rec_byte) : base_crc;
        n_ver     = base_ver;
        n_low     = base_low;
        n_high    = base_high;
        n_cw      = base_cw;
        unique case (idx[3:2])
            2'd0: n_ver  = base_ver | shifted;
            2'd1: n_low  = base_low | shifted;
            2'd2: n_high = base_high | shifted;
            default: n_cw = base_cw | shifted;
        endcase
        o_done         = i_take && (idx == 4'd15);
        o_rec.version  = n_ver;
        o_rec.low_bits = n_low;
        o_rec.high_bits = n_high;
        o_rec.crc_word = n_cw;
        o_rec.calc     = n_crc ^ crv_pkg::CRC_ONES;
    end

    // field capture; wrap after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 4'd0;
            r_crc  <= crv_pkg::CRC_ONES;
            r_ver  <= 32'd0;
            r_low  <= 32'd0;
            r_high <= 32'd0;
            r_cw   <= 32'd0;
        end else if (i_take) begin
            r_idx <= idx + 4'd1;
            if (idx == 4'd15) begin
                r_crc  <= crv_pkg::CRC_ONES;
                r_ver  <= 32'd0;
                r_low  <= 32'd0;
                r_high <= 32'd0;
                r_cw   <= 32'd0;
            end else begin
                r_crc  <= n_crc;
                r_ver  <= n_ver;
                r_low  <= n_low;
                r_high <= n_high;
                r_cw   <= n_cw;
            end
        end
    end

endmodule

FILE: hw/rtl/crv_verdict.sv
module crv_verdict (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  crv_pkg::t_record    i_rec,
    input  logic [31:0]         i_expected_version,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_valid_res,
    output logic [2:0]          o_fail_code,
    output logic [31:0]         o_computed_crc,
    output logic [31:0]         o_stored_crc,
    output logic [31:0]         o_version_seen
);

    logic              r_valid;
    crv_pkg::t_fail    r_code;
    crv_pkg::t_record  r_rec;
    crv_pkg::t_fail    n_code;

    // checks in priority order
    always_comb begin
        priority if (i_rec.version != i_expected_version) begin
            n_code = crv_pkg::FAIL_VER;
        end else if (&i_rec.low_bits[30:23] || &i_rec.high_bits[30:23]) begin
            n_code = crv_pkg::FAIL_NONFIN;
        end else if (crv_pkg::f_lt(i_rec.low_bits, 32'd0) ||
                     !crv_pkg::f_lt(i_rec.low_bits, i_rec.high_bits) ||
                     crv_pkg::f_lt(crv_pkg::FOUR_BITS, i_rec.high_bits)) begin
            n_code = crv_pkg::FAIL_RANGE;
        end else if (i_rec.calc != i_rec.crc_word) begin
            n_code = crv_pkg::FAIL_CRC;
        end else begin
            n_code = crv_pkg::FAIL_OK;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= n_code;
            r_rec  <= i_rec;
        end
    end

    assign o_valid        = r_valid;
    assign o_valid_res    = (r_code == crv_pkg::FAIL_OK);
    assign o_fail_code    = r_code;
    assign o_computed_crc = r_rec.calc;
    assign o_stored_crc   = r_rec.crc_word;
    assign o_version_seen = r_rec.version;

endmodule

FILE: hw/rtl/calibration_record_validator_unit.sv
// calibration record validator
// input channel: i_valid / o_stall with i_rec_byte and i_first, one record
//   byte per transfer, 16 bytes per record, little-endian fields
// i_first marks byte 0 and drops any partial record
// output channel: o_valid / i_stall, one verdict per record with valid_res,
//   fail_code, computed crc, stored crc and version word
// config channel: i_cfg_valid / o_cfg_ready writes expected_version
//   (reset value 1), always ready
// throughput: one byte per cycle while o_stall is low; the verdict appears in
//   the cycle after the transfer of byte 15
// the byte crc update and field capture are combinational logic; the checks
//   sit in front of the result register
// when the receiver stalls, the result holds and the input is stalled for
//   every byte while a verdict waits in the result register
// reset (synchronous, active low) clears the byte count, crc and result valid
module calibration_record_validator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rec_byte,
    input  logic        i_first,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [2:0]  o_fail_code,
    output logic [31:0] o_computed_crc,
    output logic [31:0] o_stored_crc,
    output logic [31:0] o_version_seen,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]      r_exp_ver;
    logic             take;
    logic             done;
    crv_pkg::t_record rec;

    // stall only while the result register is full and held
    assign o_stall     = o_valid && i_stall;
    assign take        = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // expected version register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver <= 32'd1;
        end else if (i_cfg_valid) begin
            r_exp_ver <= i_cfg_data;
        end
    end

    crv_collect u_collect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_rec_byte (i_rec_byte),
        .i_first    (i_first),
        .o_done     (done),
        .o_rec      (rec)
    );

    crv_verdict u_verdict (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (done),
        .i_rec              (rec),
        .i_expected_version (r_exp_ver),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_valid_res        (o_valid_res),
        .o_fail_code        (o_fail_code),
        .o_computed_crc     (o_computed_crc),
        .o_stored_crc       (o_stored_crc),
        .o_version_seen     (o_version_seen)
    );

endmodule
